// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file fpq_checker.sv
// each expands to a labeled concurrent assertion clocked on clk, disabled in rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/fpq_pkg.sv =====
// types and constants of the five-level priority queue
// no dependencies
package fpq_pkg;

  localparam int SENDER_W  = 16;
  localparam int PAYLOAD_W = 32;
  localparam int LEVEL_W   = 3;
  localparam int COUNT_W   = 7;
  localparam int ENTRY_W   = SENDER_W + PAYLOAD_W;
  localparam int RESULT_LIMIT = 64;

  typedef enum logic [1:0] {
    REQ_SEND     = 2'd0,
    REQ_PURGE    = 2'd1,
    REQ_PROMOTE  = 2'd2,
    REQ_ANNOUNCE = 2'd3
  } req_type_t;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_DROP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SW_START,
    ST_SW_WR,
    ST_SW_DONE,
    ST_AN_SEL,
    ST_AN_DATA,
    ST_OUT_WAIT
  } state_t;

endpackage

// ===== sv/fpq_req_if.sv =====
// request channel of the priority queue
// depends on fpq_pkg
interface fpq_req_if;
  import fpq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [SENDER_W-1:0]  sender_id;
  logic [LEVEL_W-1:0]   level;
  logic [PAYLOAD_W-1:0] payload;
  logic [COUNT_W-1:0]   count;
  modport source(output valid, req_type, sender_id, level, payload, count, input ready);
  modport sink(input valid, req_type, sender_id, level, payload, count, output ready);
endinterface

// ===== sv/fpq_rsp_if.sv =====
// result channel of the priority queue
// depends on fpq_pkg
interface fpq_rsp_if;
  import fpq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SENDER_W-1:0]  out_sender;
  logic [LEVEL_W-1:0]   out_level;
  logic [PAYLOAD_W-1:0] out_payload;
  logic                 status;
  logic                 last;
  modport source(output valid, out_sender, out_level, out_payload, status, last, input ready);
  modport sink(input valid, out_sender, out_level, out_payload, status, last, output ready);
endinterface

// ===== sv/five_level_priority_queue.sv =====
// Five-level priority queue: NUM_LEVELS ring FIFOs of LEVEL_DEPTH entries in one RAM,
// level 0 highest. A dropped send adds one result beat. An announce pops entries from
// level 0 down, passes empty levels and waits while a result beat is stalled. Purge
// sweeps every level and promote every level but level 0, through the single RAM read
// port at one entry per cycle. The request channel is ready only while no request is
// in progress.
module five_level_priority_queue #(
  parameter int LEVEL_DEPTH = 64,
  parameter int NUM_LEVELS  = 5
) (
  input  logic      clk,
  input  logic      rst,
  fpq_req_if.sink   req,
  fpq_rsp_if.source rsp
);
  import fpq_pkg::*;

  localparam int PW    = $clog2(LEVEL_DEPTH);
  localparam int FW    = $clog2(LEVEL_DEPTH + 1);
  localparam int LIW   = $clog2(NUM_LEVELS);
  localparam int LCW   = $clog2(NUM_LEVELS + 1);
  localparam int DEPTH = NUM_LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  state_t state, state_next;

  logic [PW-1:0] head [NUM_LEVELS];
  logic [PW-1:0] head_next [NUM_LEVELS];
  logic [FW-1:0] fill [NUM_LEVELS];
  logic [FW-1:0] fill_next [NUM_LEVELS];
  logic [LCW-1:0] lvl, lvl_next;
  logic [SENDER_W-1:0] snd, snd_next;
  logic is_promote, is_promote_next;
  logic [FW-1:0] n, n_next, k, k_next, w, w_next;
  logic [COUNT_W-1:0] cnt, cnt_next;

  logic out_valid, out_valid_next;
  logic [SENDER_W-1:0] out_sender, out_sender_next;
  logic [LEVEL_W-1:0] out_level, out_level_next;
  logic [PAYLOAD_W-1:0] out_payload, out_payload_next;
  logic out_status, out_status_next;
  logic out_last, out_last_next;

  logic [LIW-1:0] cur, tgt, send_lvl;
  logic [LIW-1:0] rd_lvl, wr_lvl;
  logic [PW-1:0] rd_head, wr_head;
  logic [FW-1:0] rd_pos, wr_pos;
  logic [AW-1:0] raddr, waddr;
  logic re, we;
  logic [ENTRY_W-1:0] wdata, rdata;
  logic accept, match, move, others;
  logic [SENDER_W-1:0] rd_sender;

  assign cur       = lvl[LIW-1:0];
  assign tgt       = cur - LIW'(1);
  assign accept    = req.valid && req.ready;
  assign rd_sender = rdata[ENTRY_W-1:PAYLOAD_W];
  assign match     = (rd_sender == snd);
  assign move      = is_promote && match && (fill[tgt] < FW'(LEVEL_DEPTH));
  assign send_lvl  = (32'(req.level) >= 32'(NUM_LEVELS)) ? LIW'(NUM_LEVELS - 1)
                                                         : LIW'(req.level);

  always_comb begin
    others = 1'b0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (LIW'(i) == cur) begin
        others = others | (fill[i] > FW'(1));
      end else begin
        others = others | (fill[i] != '0);
      end
    end
  end

  fpq_slot #(.LEVEL_DEPTH(LEVEL_DEPTH), .NUM_LEVELS(NUM_LEVELS)) u_rd_slot (
    .lvl(rd_lvl), .head(rd_head), .pos(rd_pos), .addr(raddr)
  );

  fpq_slot #(.LEVEL_DEPTH(LEVEL_DEPTH), .NUM_LEVELS(NUM_LEVELS)) u_wr_slot (
    .lvl(wr_lvl), .head(wr_head), .pos(wr_pos), .addr(waddr)
  );

  fpq_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_t'(req.req_type))
            REQ_SEND: begin
              if (fill[send_lvl] >= FW'(LEVEL_DEPTH)) begin
                state_next = ST_OUT_WAIT;
              end
            end
            REQ_PURGE, REQ_PROMOTE: state_next = ST_SW_START;
            REQ_ANNOUNCE: state_next = ST_AN_SEL;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SW_START: begin
        if (lvl == LCW'(NUM_LEVELS)) begin
          state_next = ST_IDLE;
        end else if (fill[cur] != '0) begin
          state_next = ST_SW_WR;
        end
      end
      ST_SW_WR: begin
        if (k + FW'(1) >= n) begin
          state_next = ST_SW_DONE;
        end
      end
      ST_SW_DONE: state_next = ST_SW_START;
      ST_AN_SEL: begin
        if (cnt == '0 || lvl == LCW'(NUM_LEVELS)) begin
          state_next = ST_IDLE;
        end else if (fill[cur] != '0) begin
          state_next = ST_AN_DATA;
        end
      end
      ST_AN_DATA: state_next = ST_OUT_WAIT;
      ST_OUT_WAIT: begin
        if (rsp.ready) begin
          state_next = out_last ? ST_IDLE : ST_AN_SEL;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_next        = head;
    fill_next        = fill;
    lvl_next         = lvl;
    snd_next         = snd;
    is_promote_next  = is_promote;
    n_next           = n;
    k_next           = k;
    w_next           = w;
    cnt_next         = cnt;
    out_valid_next   = out_valid;
    out_sender_next  = out_sender;
    out_level_next   = out_level;
    out_payload_next = out_payload;
    out_status_next  = out_status;
    out_last_next    = out_last;
    re     = 1'b0;
    we     = 1'b0;
    rd_lvl = cur;
    rd_head = head[cur];
    rd_pos = '0;
    wr_lvl = cur;
    wr_head = head[cur];
    wr_pos = w;
    wdata  = rdata;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          snd_next = req.sender_id;
          unique case (req_type_t'(req.req_type))
            REQ_SEND: begin
              wr_lvl  = send_lvl;
              wr_head = head[send_lvl];
              wr_pos  = fill[send_lvl];
              wdata   = {req.sender_id, req.payload};
              if (fill[send_lvl] < FW'(LEVEL_DEPTH)) begin
                we = 1'b1;
                fill_next[send_lvl] = fill[send_lvl] + FW'(1);
              end else begin
                out_valid_next   = 1'b1;
                out_sender_next  = req.sender_id;
                out_level_next   = LEVEL_W'(send_lvl);
                out_payload_next = req.payload;
                out_status_next  = STATUS_DROP;
                out_last_next    = 1'b1;
              end
            end
            REQ_PURGE: begin
              is_promote_next = 1'b0;
              lvl_next = '0;
            end
            REQ_PROMOTE: begin
              is_promote_next = 1'b1;
              lvl_next = LCW'(1);
            end
            REQ_ANNOUNCE: begin
              lvl_next = '0;
              cnt_next = (req.count > COUNT_W'(RESULT_LIMIT)) ? COUNT_W'(RESULT_LIMIT)
                                                              : req.count;
            end
            default: ;
          endcase
        end
      end
      ST_SW_START: begin
        if (lvl != LCW'(NUM_LEVELS)) begin
          n_next = fill[cur];
          k_next = '0;
          w_next = '0;
          if (fill[cur] == '0) begin
            lvl_next = lvl + LCW'(1);
          end else begin
            re = 1'b1;
          end
        end
      end
      ST_SW_WR: begin
        // entry k is on the read port; fetch k+1 while writing this one back unless it is purged
        if (move) begin
          we      = 1'b1;
          wr_lvl  = tgt;
          wr_head = head[tgt];
          wr_pos  = fill[tgt];
          fill_next[tgt] = fill[tgt] + FW'(1);
        end else if (!match || is_promote) begin
          we     = 1'b1;
          w_next = w + FW'(1);
        end
        if (k + FW'(1) < n) begin
          re     = 1'b1;
          rd_pos = k + FW'(1);
          k_next = k + FW'(1);
        end
      end
      ST_SW_DONE: begin
        fill_next[cur] = w;
        lvl_next = lvl + LCW'(1);
      end
      ST_AN_SEL: begin
        if (cnt != '0 && lvl != LCW'(NUM_LEVELS)) begin
          if (fill[cur] == '0) begin
            lvl_next = lvl + LCW'(1);
          end else begin
            re = 1'b1;
          end
        end
      end
      ST_AN_DATA: begin
        out_valid_next   = 1'b1;
        out_sender_next  = rd_sender;
        out_level_next   = LEVEL_W'(cur);
        out_payload_next = rdata[PAYLOAD_W-1:0];
        out_status_next  = STATUS_OK;
        out_last_next    = (cnt == COUNT_W'(1)) || !others;
        head_next[cur]   = (head[cur] == PW'(LEVEL_DEPTH - 1)) ? '0 : head[cur] + PW'(1);
        fill_next[cur]   = fill[cur] - FW'(1);
        cnt_next         = cnt - COUNT_W'(1);
      end
      ST_OUT_WAIT: begin
        if (rsp.ready) begin
          out_valid_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      lvl       <= '0;
      cnt       <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      lvl       <= lvl_next;
      cnt       <= cnt_next;
      head      <= head_next;
      fill      <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    snd         <= snd_next;
    is_promote  <= is_promote_next;
    n           <= n_next;
    k           <= k_next;
    w           <= w_next;
    out_sender  <= out_sender_next;
    out_level   <= out_level_next;
    out_payload <= out_payload_next;
    out_status  <= out_status_next;
    out_last    <= out_last_next;
  end

  assign req.ready       = (state == ST_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.out_sender  = out_sender;
  assign rsp.out_level   = out_level;
  assign rsp.out_payload = out_payload;
  assign rsp.status      = out_status;
  assign rsp.last        = out_last;
endmodule

// ===== sv/fpq_ram.sv =====
// generic single-write, single-read RAM with registered read
// no dependencies
module fpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== sv/fpq_slot.sv =====
// ring slot address: level base plus wrapped head offset
// no dependencies
module fpq_slot #(
  parameter int LEVEL_DEPTH = 64,
  parameter int NUM_LEVELS  = 5
) (
  input  logic [$clog2(NUM_LEVELS)-1:0]              lvl,
  input  logic [$clog2(LEVEL_DEPTH)-1:0]             head,
  input  logic [$clog2(LEVEL_DEPTH+1)-1:0]           pos,
  output logic [$clog2(NUM_LEVELS*LEVEL_DEPTH)-1:0]  addr
);
  localparam int PW = $clog2(LEVEL_DEPTH);
  localparam int FW = $clog2(LEVEL_DEPTH + 1);
  localparam int AW = $clog2(NUM_LEVELS * LEVEL_DEPTH);

  logic [FW:0] sum;
  logic [PW-1:0] offs;

  always_comb begin
    sum = (FW+1)'(head) + (FW+1)'(pos);
    // both terms below depth, so one subtract wraps
    if (sum >= (FW+1)'(LEVEL_DEPTH)) begin
      offs = PW'(sum - (FW+1)'(LEVEL_DEPTH));
    end else begin
      offs = PW'(sum);
    end
    addr = AW'(AW'(lvl) * AW'(LEVEL_DEPTH)) + AW'(offs);
  end
endmodule

// ===== sv/fpq_checker.sv =====
// port-level checks of the priority queue, bound to the top level
// depends on fpq_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpq_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_type,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic       rsp_last
);
  import fpq_pkg::*;

  logic sweep_req;

  assign sweep_req = req_valid && req_ready &&
                     (req_type == REQ_PURGE || req_type == REQ_PROMOTE);

  // no new request while a result beat is pending
  `ASSERT_NOW(a_ready_excl, req_ready, !rsp_valid)
  // purge and promote give no result
  `ASSERT_NEXT(a_sweep_silent, sweep_req, !rsp_valid)
  // the final beat of a request ends the output burst
  `ASSERT_NEXT(a_last_ends, rsp_valid && rsp_ready && rsp_last, !rsp_valid)
  // a stalled beat stays up
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind five_level_priority_queue fpq_checker u_fpq_checker (
  .clk(clk),
  .rst(rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .req_type(req.req_type),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .rsp_last(rsp.last)
);

// ===== dv/tb_five_level_priority_queue.sv =====
// testbench of the five-level priority queue: random and directed requests,
// results checked beat by beat against a behavioral model of the levels
// depends on fpq_pkg, fpq_req_if, fpq_rsp_if and five_level_priority_queue
`timescale 1ns / 100ps
module tb_five_level_priority_queue;
  import fpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int LEVELS = 5;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    req_type_t            kind;
    logic [SENDER_W-1:0]  sender;
    logic [LEVEL_W-1:0]   lvl;
    logic [PAYLOAD_W-1:0] payload;
    logic [COUNT_W-1:0]   count;
  } request_t;

  typedef struct packed {
    logic [SENDER_W-1:0]  sender;
    logic [LEVEL_W-1:0]   lvl;
    logic [PAYLOAD_W-1:0] payload;
    logic                 status;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [SENDER_W-1:0]  sender;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  fpq_req_if req ();
  fpq_rsp_if rsp ();

  five_level_priority_queue u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  request_t pending_reqs[$];
  result_t  expected_results[$];
  entry_t   level_q[LEVELS][$];
  int       mismatches = 0;
  int       idle_pct = 36;
  bit       hold_send = 1'b0;
  int       quiet_cycles = 0;

  task automatic report(input string what, input result_t got, input result_t exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    mismatches++;
  endtask

  // applies one request to the level model and queues its results
  function automatic void queue_model(input request_t r);
    int lv;
    int n;
    entry_t e;
    entry_t kept[$];
    result_t res;
    case (r.kind)
      REQ_SEND: begin
        lv = (r.lvl >= LEVELS) ? LEVELS - 1 : int'(r.lvl);
        e.sender = r.sender;
        e.payload = r.payload;
        if (level_q[lv].size() < DEPTH) begin
          level_q[lv].push_back(e);
        end else begin
          res.sender = r.sender;
          res.lvl = lv[LEVEL_W-1:0];
          res.payload = r.payload;
          res.status = STATUS_DROP;
          res.last = 1'b1;
          expected_results.push_back(res);
        end
      end
      REQ_PURGE: begin
        for (int l = 0; l < LEVELS; l++) begin
          kept = {};
          for (int k = 0; k < level_q[l].size(); k++) begin
            if (level_q[l][k].sender != r.sender) kept.push_back(level_q[l][k]);
          end
          level_q[l] = kept;
        end
      end
      REQ_PROMOTE: begin
        for (int l = 1; l < LEVELS; l++) begin
          kept = {};
          for (int k = 0; k < level_q[l].size(); k++) begin
            e = level_q[l][k];
            if (e.sender == r.sender && level_q[l-1].size() < DEPTH)
              level_q[l-1].push_back(e);
            else kept.push_back(e);
          end
          level_q[l] = kept;
        end
      end
      default: begin
        n = (r.count > RESULT_LIMIT) ? RESULT_LIMIT : int'(r.count);
        for (int l = 0; l < LEVELS; l++) begin
          while (n > 0 && level_q[l].size() > 0) begin
            e = level_q[l].pop_front();
            res.sender = e.sender;
            res.lvl = l[LEVEL_W-1:0];
            res.payload = e.payload;
            res.status = STATUS_OK;
            res.last = 1'b0;
            expected_results.push_back(res);
            n--;
          end
        end
        if (n != ((r.count > RESULT_LIMIT) ? RESULT_LIMIT : int'(r.count)))
          expected_results[$].last = 1'b1;
      end
    endcase
  endfunction

  function automatic request_t make_req(input req_type_t k, input int snd, input int lv,
                                        input logic [31:0] pay, input int cnt);
    request_t r;
    r.kind = k;
    r.sender = snd[15:0];
    r.lvl = lv[2:0];
    r.payload = pay;
    r.count = cnt[6:0];
    return r;
  endfunction

  // small pool of senders so purges and promotes hit real entries
  function automatic int pick_sender();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 5) * 16'h1111 ^ $urandom_range(0, 1);
  endfunction

  function automatic request_t random_req();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55)
      return make_req(REQ_SEND, pick_sender(), $urandom_range(0, 7), $urandom(),
                      $urandom_range(0, 127));
    if (sel < 65)
      return make_req(REQ_PURGE, pick_sender(), $urandom_range(0, 7), $urandom(),
                      $urandom_range(0, 127));
    if (sel < 78)
      return make_req(REQ_PROMOTE, pick_sender(), $urandom_range(0, 7), $urandom(),
                      $urandom_range(0, 127));
    return make_req(REQ_ANNOUNCE, pick_sender(), $urandom_range(0, 7), $urandom(),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() > 0 && !hold_send && $urandom_range(0, 99) >= idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        queue_model(r);
        req.valid <= 1'b1;
        req.req_type <= r.kind;
        req.sender_id <= r.sender;
        req.level <= r.lvl;
        req.payload <= r.payload;
        req.count <= r.count;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        result_t got;
        result_t exp;
        got = {rsp.out_sender, rsp.out_level, rsp.out_payload, rsp.status, rsp.last};
        if (expected_results.size() == 0) begin
          report("unexpected beat", got, got);
        end else begin
          exp = expected_results.pop_front();
          if (got.sender !== exp.sender) report("sender", got, exp);
          if (got.lvl !== exp.lvl) report("level", got, exp);
          if (got.payload !== exp.payload) report("payload", got, exp);
          if (got.status !== exp.status) report("status", got, exp);
          if (got.last !== exp.last) report("last", got, exp);
        end
      end
      rsp.ready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.req_type = REQ_SEND;
    req.sender_id = '0;
    req.level = '0;
    req.payload = '0;
    req.count = '0;
    rsp.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, empty announce, out-of-range level, overflow, full promote
    pending_reqs.push_back(make_req(REQ_ANNOUNCE, 0, 0, 0, 5));
    pending_reqs.push_back(make_req(REQ_SEND, 16'hffff, 0, 32'hffffffff, 127));
    pending_reqs.push_back(make_req(REQ_SEND, 0, 7, 0, 0));
    pending_reqs.push_back(make_req(REQ_SEND, 16'h5555, 5, 32'haaaa5555, 0));
    pending_reqs.push_back(make_req(REQ_SEND, 16'haaaa, 3, 32'h5555aaaa, 0));
    pending_reqs.push_back(make_req(REQ_ANNOUNCE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_PROMOTE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_PURGE, 16'hffff, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_ANNOUNCE, 0, 0, 0, 127));
    for (int i = 0; i < 66; i++)
      pending_reqs.push_back(make_req(REQ_SEND, i % 3, 0, $urandom(), 0));
    for (int i = 0; i < 4; i++)
      pending_reqs.push_back(make_req(REQ_SEND, 1, 1, $urandom(), 0));
    pending_reqs.push_back(make_req(REQ_PROMOTE, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_PURGE, 2, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_ANNOUNCE, 0, 0, 0, 64));
    pending_reqs.push_back(make_req(REQ_ANNOUNCE, 0, 0, 0, 100));
    while (pending_reqs.size() > 0) @(posedge clk);

    // sender holds off until the queue has drained
    hold_send = 1'b1;
    while (expected_results.size() > 0) @(posedge clk);
    hold_send = 1'b0;

    // random, with a stretch of no idling in the middle
    for (int i = 0; i < 340; i++) begin
      idle_pct = (i >= 120 && i < 200) ? 0 : 36;
      pending_reqs.push_back(random_req());
      while (pending_reqs.size() > 0) @(posedge clk);
    end
    pending_reqs.push_back(make_req(REQ_ANNOUNCE, 0, 0, 0, 127));
    while (pending_reqs.size() > 0) @(posedge clk);
    idle_pct = 36;

    while (expected_results.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fpq_pkg.sv
sv/fpq_req_if.sv
sv/fpq_rsp_if.sv
sv/fpq_ram.sv
sv/fpq_slot.sv
sv/five_level_priority_queue.sv
sv/fpq_checker.sv
dv/tb_five_level_priority_queue.sv
